[sv/nrc_pkg.sv]
// ----------------------------------------------------------------------------
// nrc_pkg
// shared types, characters and helpers of the rmc sentence checker
// ----------------------------------------------------------------------------
`default_nettype none

package nrc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [26:0] TIME_MAX  = 27'd99999999;
  localparam logic [19:0] WHOLE_MAX = 20'd99999;
  localparam logic [19:0] FRAC_MAX  = 20'd999999;
  localparam logic [19:0] IP_MAX    = 20'd1000000;

  localparam int unsigned FIELD_W = 27;
  localparam int unsigned NFIELDS = 8;

  typedef enum logic [3:0] {
    PS_HEAD,
    PS_TWS,
    PS_TINT,
    PS_TDOT,
    PS_TFRAC,
    PS_LIT,
    PS_CHAR,
    PS_IWS,
    PS_ISGN,
    PS_IDIG,
    PS_DONE
  } parse_state_t;

  typedef enum logic [1:0] {
    CS_SUM,
    CS_HEX1,
    CS_HEX2,
    CS_END
  } cs_state_t;

  typedef struct packed {
    logic [3:0]                           taken;
    logic [NFIELDS-1:0][FIELD_W-1:0]      fields;
  } parse_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

  function automatic logic [7:0] head_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4D;
      3'd4:    c = 8'h43;
      default: c = CH_COMMA;
    endcase
    return c;
  endfunction

  // separator in front of each field
  function automatic logic [7:0] lit_char(input logic [2:0] f);
    return ((f == 3'd3) || (f == 3'd6)) ? CH_DOT : CH_COMMA;
  endfunction

  function automatic logic is_char_field(input logic [2:0] f);
    return (f == 3'd1) || (f == 3'd4) || (f == 3'd7);
  endfunction

endpackage

`default_nettype wire

[sv/nmea_rmc_sentence_checker.sv]
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_checker
// Takes one received byte per cycle while in_stall is low. Checksum and field
// parsing run on the fly as each byte arrives, restarting at every '$', so a
// line needs no pass at its end: the line-ending byte (newline, or any byte
// once LINE_CAPACITY bytes are held) yields one result word the next cycle.
// Input bytes are taken while a result waits, except a line-ending byte.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_rmc_sentence_checker #(
  parameter int unsigned LINE_CAPACITY = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             sentence_ok,
  output logic [3:0]       fields_taken,
  output logic [26:0]      time_hundredths,
  output logic [7:0]       fix_status,
  output logic [16:0]      lat_whole,
  output logic [19:0]      lat_frac,
  output logic [7:0]       north_south,
  output logic [16:0]      lon_whole,
  output logic [19:0]      lon_frac,
  output logic [7:0]       east_west
);

  localparam int unsigned FILL_W = $clog2(LINE_CAPACITY + 1);

  logic [FILL_W-1:0] fill;
  logic              term, accept, finish, restart, feed;
  logic [7:0]        ch;
  logic              cs_ok;
  nrc_pkg::parse_result_t pres;
  logic [nrc_pkg::NFIELDS-1:0][nrc_pkg::FIELD_W-1:0] held;

  assign term    = (rx_byte == nrc_pkg::CH_NL) || (fill == FILL_W'(LINE_CAPACITY));
  assign in_stall = out_valid && out_stall && term;
  assign accept  = in_valid && !in_stall;
  assign finish  = accept && term;
  assign restart = finish || (accept && (rx_byte == nrc_pkg::CH_DOLLAR));
  assign feed    = finish || (accept && (fill != '0) && (rx_byte != nrc_pkg::CH_DOLLAR));
  assign ch      = term ? nrc_pkg::CH_NUL : rx_byte;

  nrc_checksum u_cs (
    .clk     (clk),
    .rst     (rst),
    .feed    (feed),
    .restart (restart),
    .ch      (ch),
    .ok_next (cs_ok)
  );

  nrc_field_parser u_parse (
    .clk     (clk),
    .rst     (rst),
    .feed    (feed),
    .restart (restart),
    .ch      (ch),
    .result  (pres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      out_valid    <= 1'b0;
      sentence_ok  <= 1'b0;
      fields_taken <= '0;
      held         <= '0;
    end else begin
      out_valid <= finish || (out_valid && out_stall);
      if (finish) begin
        fill         <= '0;
        sentence_ok  <= cs_ok;
        fields_taken <= cs_ok ? pres.taken : 4'd0;
        for (int i = 0; i < nrc_pkg::NFIELDS; i++) begin
          if (cs_ok && (4'(i) < pres.taken)) held[i] <= pres.fields[i];
        end
      end else if (accept) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

  assign time_hundredths = held[0];
  assign fix_status      = held[1][7:0];
  assign lat_whole       = held[2][16:0];
  assign lat_frac        = held[3][19:0];
  assign north_south     = held[4][7:0];
  assign lon_whole       = held[5][16:0];
  assign lon_frac        = held[6][19:0];
  assign east_west       = held[7][7:0];

endmodule

`default_nettype wire

[sv/nrc_checksum.sv]
// ----------------------------------------------------------------------------
// nrc_checksum
// running xor up to the star and compare against two uppercase hex digits
// ----------------------------------------------------------------------------
`default_nettype none

module nrc_checksum (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       feed,
  input  wire logic       restart,
  input  wire logic [7:0] ch,
  output logic            ok_next
);

  nrc_pkg::cs_state_t state, state_next;
  logic [7:0] sum, sum_next;
  logic       hi_ok, hi_ok_next;
  logic       ok;

  always_comb begin
    state_next = state;
    sum_next   = sum;
    hi_ok_next = hi_ok;
    ok_next    = ok;
    unique case (state)
      nrc_pkg::CS_SUM: begin
        if (ch == nrc_pkg::CH_STAR) begin
          state_next = nrc_pkg::CS_HEX1;
        end else if (ch == nrc_pkg::CH_NUL) begin
          state_next = nrc_pkg::CS_END;
          ok_next    = 1'b0;
        end else begin
          sum_next = sum ^ ch;
        end
      end
      nrc_pkg::CS_HEX1: begin
        hi_ok_next = (ch == nrc_pkg::hex_char(sum[7:4]));
        state_next = nrc_pkg::CS_HEX2;
      end
      nrc_pkg::CS_HEX2: begin
        ok_next    = hi_ok && (ch == nrc_pkg::hex_char(sum[3:0]));
        state_next = nrc_pkg::CS_END;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= nrc_pkg::CS_SUM;
      sum   <= '0;
      hi_ok <= 1'b0;
      ok    <= 1'b0;
    end else if (feed) begin
      state <= state_next;
      sum   <= sum_next;
      hi_ok <= hi_ok_next;
      ok    <= ok_next;
    end
  end

endmodule

`default_nettype wire

[sv/nrc_field_parser.sv]
// ----------------------------------------------------------------------------
// nrc_field_parser
// streaming parse of the gprmc fields, one character per step
// ----------------------------------------------------------------------------
`default_nettype none

module nrc_field_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  feed,
  input  wire logic                  restart,
  input  wire logic [7:0]            ch,
  output nrc_pkg::parse_result_t     result
);

  nrc_pkg::parse_state_t state, state_next;
  logic [2:0]  hidx, hidx_next;
  logic [2:0]  fidx, fidx_next;
  logic [3:0]  taken, taken_next;
  logic        neg, neg_next;
  logic        any, any_next;
  logic [19:0] ip, ip_next;
  logic [6:0]  fr, fr_next;
  logic [1:0]  nf, nf_next;
  logic [19:0] acc, acc_next;
  logic [nrc_pkg::NFIELDS-1:0][nrc_pkg::FIELD_W-1:0] shadow;

  logic        dig;
  logic [3:0]  dval;
  logic [23:0] ip_mac, acc_mac;
  logic [19:0] cap;
  logic [6:0]  fr_scaled;
  logic [27:0] tsum;
  logic [26:0] time_val;
  logic        lit_now;
  logic [2:0]  lit_idx;
  logic        we;
  logic [2:0]  widx;
  logic [26:0] wval;

  assign dig     = nrc_pkg::is_digit(ch);
  assign dval    = ch[3:0];
  assign ip_mac  = 24'(ip) * 24'd10 + 24'(dval);
  assign acc_mac = 24'(acc) * 24'd10 + 24'(dval);
  assign cap     = ((fidx == 3'd2) || (fidx == 3'd5)) ? nrc_pkg::WHOLE_MAX : nrc_pkg::FRAC_MAX;
  assign fr_scaled = (nf == 2'd0) ? 7'd0 : (nf == 2'd1) ? 7'(fr * 7'd10) : fr;
  assign tsum    = 28'(ip) * 28'd100 + 28'(fr_scaled);
  assign time_val = neg ? '0 : (tsum > 28'(nrc_pkg::TIME_MAX)) ? nrc_pkg::TIME_MAX : tsum[26:0];

  always_comb begin
    state_next = state;
    hidx_next  = hidx;
    fidx_next  = fidx;
    taken_next = taken;
    neg_next   = neg;
    any_next   = any;
    ip_next    = ip;
    fr_next    = fr;
    nf_next    = nf;
    acc_next   = acc;
    lit_now    = 1'b0;
    lit_idx    = fidx;
    we         = 1'b0;
    widx       = fidx;
    wval       = '0;
    unique case (state)
      nrc_pkg::PS_HEAD: begin
        if (ch == nrc_pkg::head_char(hidx)) begin
          if (hidx == 3'd5) state_next = nrc_pkg::PS_TWS;
          else hidx_next = hidx + 3'd1;
        end else begin
          state_next = nrc_pkg::PS_DONE;
        end
      end
      nrc_pkg::PS_TWS: begin
        if (nrc_pkg::is_ws(ch)) begin
        end else if ((ch == nrc_pkg::CH_PLUS) || (ch == nrc_pkg::CH_MINUS)) begin
          neg_next   = (ch == nrc_pkg::CH_MINUS);
          state_next = nrc_pkg::PS_TINT;
        end else if (dig) begin
          ip_next    = 20'(dval);
          any_next   = 1'b1;
          state_next = nrc_pkg::PS_TINT;
        end else if (ch == nrc_pkg::CH_DOT) begin
          state_next = nrc_pkg::PS_TDOT;
        end else begin
          state_next = nrc_pkg::PS_DONE;
        end
      end
      nrc_pkg::PS_TINT: begin
        if (dig) begin
          ip_next  = (ip_mac > 24'(nrc_pkg::IP_MAX)) ? nrc_pkg::IP_MAX : ip_mac[19:0];
          any_next = 1'b1;
        end else if (ch == nrc_pkg::CH_DOT) begin
          state_next = any ? nrc_pkg::PS_TFRAC : nrc_pkg::PS_TDOT;
        end else if (any) begin
          we         = 1'b1;
          widx       = 3'd0;
          wval       = time_val;
          taken_next = 4'd1;
          lit_now    = 1'b1;
          lit_idx    = 3'd1;
        end else begin
          state_next = nrc_pkg::PS_DONE;
        end
      end
      nrc_pkg::PS_TDOT: begin
        if (dig) begin
          fr_next    = 7'(dval);
          nf_next    = 2'd1;
          any_next   = 1'b1;
          state_next = nrc_pkg::PS_TFRAC;
        end else begin
          state_next = nrc_pkg::PS_DONE;
        end
      end
      nrc_pkg::PS_TFRAC: begin
        if (dig) begin
          if (nf < 2'd2) begin
            fr_next = 7'(fr * 7'd10 + 7'(dval));
            nf_next = nf + 2'd1;
          end
        end else begin
          we         = 1'b1;
          widx       = 3'd0;
          wval       = time_val;
          taken_next = 4'd1;
          lit_now    = 1'b1;
          lit_idx    = 3'd1;
        end
      end
      nrc_pkg::PS_LIT: begin
        lit_now = 1'b1;
      end
      nrc_pkg::PS_CHAR: begin
        if (ch != nrc_pkg::CH_NUL) begin
          we         = 1'b1;
          wval       = 27'(ch);
          taken_next = {1'b0, fidx} + 4'd1;
          if (fidx == 3'd7) begin
            state_next = nrc_pkg::PS_DONE;
          end else begin
            fidx_next  = fidx + 3'd1;
            state_next = nrc_pkg::PS_LIT;
          end
        end else begin
          state_next = nrc_pkg::PS_DONE;
        end
      end
      nrc_pkg::PS_IWS: begin
        if (nrc_pkg::is_ws(ch)) begin
        end else if ((ch == nrc_pkg::CH_PLUS) || (ch == nrc_pkg::CH_MINUS)) begin
          neg_next   = (ch == nrc_pkg::CH_MINUS);
          state_next = nrc_pkg::PS_ISGN;
        end else if (dig) begin
          acc_next   = 20'(dval);
          state_next = nrc_pkg::PS_IDIG;
        end else begin
          state_next = nrc_pkg::PS_DONE;
        end
      end
      nrc_pkg::PS_ISGN: begin
        if (dig) begin
          acc_next   = 20'(dval);
          state_next = nrc_pkg::PS_IDIG;
        end else begin
          state_next = nrc_pkg::PS_DONE;
        end
      end
      nrc_pkg::PS_IDIG: begin
        if (dig) begin
          acc_next = (acc_mac > 24'(cap)) ? cap : acc_mac[19:0];
        end else begin
          we         = 1'b1;
          wval       = neg ? '0 : 27'(acc);
          taken_next = {1'b0, fidx} + 4'd1;
          lit_now    = 1'b1;
          lit_idx    = fidx + 3'd1;
        end
      end
      default: begin
      end
    endcase
    if (lit_now) begin
      if (ch == nrc_pkg::lit_char(lit_idx)) begin
        fidx_next  = lit_idx;
        neg_next   = 1'b0;
        state_next = nrc_pkg::is_char_field(lit_idx) ? nrc_pkg::PS_CHAR : nrc_pkg::PS_IWS;
      end else begin
        state_next = nrc_pkg::PS_DONE;
      end
    end
  end

  always_comb begin
    result.taken = taken_next;
    for (int i = 0; i < nrc_pkg::NFIELDS; i++) begin
      result.fields[i] = (we && (widx == 3'(i))) ? wval : shadow[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= nrc_pkg::PS_HEAD;
      hidx  <= '0;
      fidx  <= '0;
      taken <= '0;
      neg   <= 1'b0;
      any   <= 1'b0;
      ip    <= '0;
      fr    <= '0;
      nf    <= '0;
      acc   <= '0;
    end else if (feed) begin
      state <= state_next;
      hidx  <= hidx_next;
      fidx  <= fidx_next;
      taken <= taken_next;
      neg   <= neg_next;
      any   <= any_next;
      ip    <= ip_next;
      fr    <= fr_next;
      nf    <= nf_next;
      acc   <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (feed && we) begin
      shadow[widx] <= wval;
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nmea_rmc_sentence_checker. Serial bytes are sent one
// byte at a time. A software model of the line store, the checksum and the
// rmc field scan predicts each line-end result. The results are compared
// field by field as they come out. Directed lines come first, then random
// sentences with valid and broken checksums, plus noise.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = 128;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic        ok;
    logic [3:0]  taken;
    logic [26:0] fields [8];
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        sentence_ok;
  logic [3:0]  fields_taken;
  logic [26:0] time_hundredths;
  logic [7:0]  fix_status;
  logic [16:0] lat_whole;
  logic [19:0] lat_frac;
  logic [7:0]  north_south;
  logic [16:0] lon_whole;
  logic [19:0] lon_frac;
  logic [7:0]  east_west;

  nmea_rmc_sentence_checker #(.LINE_CAPACITY(CAP)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .sentence_ok(sentence_ok),
    .fields_taken(fields_taken), .time_hundredths(time_hundredths),
    .fix_status(fix_status), .lat_whole(lat_whole), .lat_frac(lat_frac),
    .north_south(north_south), .lon_whole(lon_whole), .lon_frac(lon_frac),
    .east_west(east_west)
  );

  always #4 clk = ~clk;

  logic [7:0]   line_buf [CAP];
  int unsigned  line_len;
  logic [26:0]  held [8];
  logic [26:0]  shadow [8];
  line_result_t pending_lines [$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  stall_left = 0;
  logic         idle_on;

  function automatic logic [7:0] char_at(int unsigned i);
    return (i < line_len) ? line_buf[i] : 8'h00;
  endfunction

  function automatic logic is_sp(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic scan_sign(inout int unsigned p);
    logic [7:0] c;
    while (is_sp(char_at(p))) p++;
    c = char_at(p);
    if (c == nrc_pkg::CH_PLUS || c == nrc_pkg::CH_MINUS) begin
      p++;
      return c == nrc_pkg::CH_MINUS;
    end
    return 1'b0;
  endfunction

  function automatic logic scan_int(inout int unsigned p, input int unsigned cap,
                                    output logic [26:0] val);
    logic neg;
    int unsigned v;
    neg = scan_sign(p);
    v = 0;
    val = '0;
    if (!is_dec(char_at(p))) return 1'b0;
    while (is_dec(char_at(p))) begin
      v = v * 10 + (char_at(p) - "0");
      if (v > cap) v = cap;
      p++;
    end
    val = neg ? 27'd0 : 27'(v);
    return 1'b1;
  endfunction

  function automatic logic scan_time(inout int unsigned p, output logic [26:0] val);
    logic neg, any;
    int unsigned ip, fr, nf, v;
    neg = scan_sign(p);
    any = 0; ip = 0; fr = 0; nf = 0;
    val = '0;
    while (is_dec(char_at(p))) begin
      ip = ip * 10 + (char_at(p) - "0");
      if (ip > 1000000) ip = 1000000;
      any = 1; p++;
    end
    if (char_at(p) == nrc_pkg::CH_DOT && (any || is_dec(char_at(p + 1)))) begin
      p++;
      while (is_dec(char_at(p))) begin
        if (nf < 2) begin
          fr = fr * 10 + (char_at(p) - "0");
          nf++;
        end
        any = 1; p++;
      end
    end
    if (!any) return 1'b0;
    while (nf < 2) begin
      fr *= 10;
      nf++;
    end
    v = ip * 100 + fr;
    if (v > 99999999) v = 99999999;
    val = neg ? 27'd0 : 27'(v);
    return 1'b1;
  endfunction

  function automatic logic scan_lit(inout int unsigned p, input logic [7:0] c);
    if (char_at(p) != c) return 1'b0;
    p++;
    return 1'b1;
  endfunction

  function automatic logic scan_chr(inout int unsigned p, output logic [26:0] val);
    val = 27'(char_at(p));
    if (char_at(p) == nrc_pkg::CH_NUL) return 1'b0;
    p++;
    return 1'b1;
  endfunction

  function automatic int unsigned scan_rmc(int unsigned p);
    string hd;
    hd = "GPRMC,";
    for (int i = 0; i < 6; i++)
      if (!scan_lit(p, hd[i])) return 0;
    if (!scan_time(p, shadow[0])) return 0;
    if (!scan_lit(p, nrc_pkg::CH_COMMA) || !scan_chr(p, shadow[1])) return 1;
    if (!scan_lit(p, nrc_pkg::CH_COMMA) || !scan_int(p, 99999, shadow[2])) return 2;
    if (!scan_lit(p, nrc_pkg::CH_DOT) || !scan_int(p, 999999, shadow[3])) return 3;
    if (!scan_lit(p, nrc_pkg::CH_COMMA) || !scan_chr(p, shadow[4])) return 4;
    if (!scan_lit(p, nrc_pkg::CH_COMMA) || !scan_int(p, 99999, shadow[5])) return 5;
    if (!scan_lit(p, nrc_pkg::CH_DOT) || !scan_int(p, 999999, shadow[6])) return 6;
    if (!scan_lit(p, nrc_pkg::CH_COMMA) || !scan_chr(p, shadow[7])) return 7;
    return 8;
  endfunction

  function automatic logic [7:0] hex_up(logic [3:0] n);
    return (n < 10) ? 8'("0") + n : 8'("A") + n - 8'd10;
  endfunction

  function automatic void close_line();
    line_result_t r;
    int unsigned start, pos;
    logic [7:0] sum;
    logic found;
    start = 0; found = 0; sum = 0;
    for (int unsigned i = 0; i < line_len; i++)
      if (line_buf[i] == nrc_pkg::CH_DOLLAR) begin
        start = i;
        found = 1;
      end
    start = found ? start + 1 : 1;
    pos = start;
    while (char_at(pos) != nrc_pkg::CH_STAR && char_at(pos) != nrc_pkg::CH_NUL) begin
      sum ^= char_at(pos);
      pos++;
    end
    r.ok = char_at(pos) == nrc_pkg::CH_STAR && char_at(pos + 1) == hex_up(sum[7:4])
           && char_at(pos + 2) == hex_up(sum[3:0]);
    r.taken = 0;
    if (r.ok) begin
      r.taken = 4'(scan_rmc(start));
      for (int i = 0; i < r.taken; i++) held[i] = shadow[i];
    end
    r.fields = held;
    pending_lines.push_back(r);
    line_len = 0;
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    if (b != nrc_pkg::CH_NL && line_len < CAP) begin
      line_buf[line_len] = b;
      line_len++;
    end else begin
      close_line();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_byte(b);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string with_sum(string body);
    logic [7:0] x;
    x = 0;
    for (int i = 0; i < body.len(); i++) x ^= body[i];
    return {"$", body, "*", string'(hex_up(x[7:4])), string'(hex_up(x[3:0]))};
  endfunction

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0") + 8'($urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_body();
    string s;
    string parts [8];
    parts[0] = ($urandom_range(0, 7) == 0) ? "-1.5" : {rand_digits($urandom_range(0, 9)),
               ($urandom_range(0, 1) ? {".", rand_digits($urandom_range(0, 4))} : "")};
    parts[1] = $urandom_range(0, 1) ? "A" : "V";
    parts[2] = {($urandom_range(0, 5) == 0 ? " -" : ""), rand_digits($urandom_range(0, 7))};
    parts[3] = rand_digits($urandom_range(0, 8));
    parts[4] = $urandom_range(0, 1) ? "N" : "S";
    parts[5] = {($urandom_range(0, 5) == 0 ? "+" : ""), rand_digits($urandom_range(0, 7))};
    parts[6] = rand_digits($urandom_range(0, 8));
    parts[7] = $urandom_range(0, 1) ? "E" : "W";
    s = {"GPRMC,", parts[0], ",", parts[1], ",", parts[2], ".", parts[3], ",", parts[4],
         ",", parts[5], ".", parts[6], ",", parts[7]};
    if ($urandom_range(0, 9) == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
    return s;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_text({with_sum("GPRMC,123519.994,A,4807.038,N,01131.000,E,022.4"), "\n"});
    send_text({with_sum("GPRMC,999999999.99,V,999999.9999999,S,-12.3,W"), "\r\n"});
    send_text({with_sum("GPRMC,\t+1.,X,12.5,N,1.x,E"), "\n"});
    send_text({with_sum("GPRMC,.5,A,,N"), "\n"});
    send_text("\n");
    send_text("$\n");
    send_text("GPRMC,1,A*00\n");
    send_text({"junk", with_sum("GPRMC,1e5,A"), "\n"});
    send_text({"$GPRMC,1,A*4", "a\n"});
    send_byte(8'h00); send_byte(8'hFF); send_text("*00\n");
    send_text({with_sum("GPRMC,1,A"), "\n"});
    for (int i = 0; i < CAP + 1; i++) send_byte(i == 0 ? nrc_pkg::CH_DOLLAR : 8'h41);
    wait_drained();
  endtask

  task automatic test_random_lines(input int unsigned n_bytes);
    int unsigned sent;
    string s;
    sent = 0;
    while (sent < n_bytes) begin
      case ($urandom_range(0, 9))
        0: begin
          s = "";
          repeat ($urandom_range(1, 12)) s = {s, string'(8'($urandom_range(0, 255)))};
          s = {s, "\n"};
        end
        1: begin
          s = with_sum(rand_body());
          s[s.len() - 1] = 8'(s[s.len() - 1] ^ (8'd1 << $urandom_range(0, 7)));
          s = {s, "\n"};
        end
        default: s = {with_sum(rand_body()), "\n"};
      endcase
      send_text(s);
      sent += s.len();
    end
  endtask

  always @(posedge clk) begin
    line_result_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_lines.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = pending_lines.pop_front();
        if (sentence_ok !== e.ok) begin
          $error("sentence_ok exp %0d got %0d", e.ok, sentence_ok); errors++;
        end
        if (fields_taken !== e.taken) begin
          $error("fields_taken exp %0d got %0d", e.taken, fields_taken); errors++;
        end
        if (time_hundredths !== e.fields[0]) begin
          $error("time_hundredths exp %0d got %0d", e.fields[0], time_hundredths); errors++;
        end
        if (fix_status !== e.fields[1][7:0]) begin
          $error("fix_status exp %0h got %0h", e.fields[1][7:0], fix_status); errors++;
        end
        if (lat_whole !== e.fields[2][16:0]) begin
          $error("lat_whole exp %0d got %0d", e.fields[2][16:0], lat_whole); errors++;
        end
        if (lat_frac !== e.fields[3][19:0]) begin
          $error("lat_frac exp %0d got %0d", e.fields[3][19:0], lat_frac); errors++;
        end
        if (north_south !== e.fields[4][7:0]) begin
          $error("north_south exp %0h got %0h", e.fields[4][7:0], north_south); errors++;
        end
        if (lon_whole !== e.fields[5][16:0]) begin
          $error("lon_whole exp %0d got %0d", e.fields[5][16:0], lon_whole); errors++;
        end
        if (lon_frac !== e.fields[6][19:0]) begin
          $error("lon_frac exp %0d got %0d", e.fields[6][19:0], lon_frac); errors++;
        end
        if (east_west !== e.fields[7][7:0]) begin
          $error("east_west exp %0h got %0h", e.fields[7][7:0], east_west); errors++;
        end
      end
    end
  end

  // random stall bursts on the result output
  always @(negedge clk) begin
    if (!out_stall && idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("nmea_rmc_sentence_checker: mismatch");
      $finish;
    end
  end

  initial begin
    line_len = 0;
    idle_on = 1'b1;
    for (int i = 0; i < 8; i++) begin
      held[i] = '0;
      shadow[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_lines(1200);
    // send pauses here until the last line is out
    wait_drained();
    idle_on = 1'b0;
    test_random_lines(350);
    send_byte(nrc_pkg::CH_NL);
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_lines.size() == 0)
      $display("nmea_rmc_sentence_checker: match");
    else
      $display("nmea_rmc_sentence_checker: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
